@@ rtl/assert_macros.svh @@
// Assertion macros used by the ring buffer unit.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH

// Property that must hold at every clock edge outside reset.
`define ASSERT_PROP(lbl, clk, rstn, prop) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (prop)) \
        else $error("assertion failed: %m");

// Condition that must never be true outside reset.
`define ASSERT_NEVER(lbl, clk, rstn, cond) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) !(cond)) \
        else $error("assertion failed: %m");

`else

`define ASSERT_PROP(lbl, clk, rstn, prop)
`define ASSERT_NEVER(lbl, clk, rstn, cond)

`endif

`endif

@@ rtl/uart_rb_pkg.sv @@
// Types, constants and pointer helpers for the UART ring buffers.
`timescale 1ns / 1ps

package uart_rb_pkg;

    localparam int RX_DEPTH = 64;
    localparam int TX_DEPTH = 64;
    localparam int RX_PW    = $clog2(RX_DEPTH);
    localparam int TX_PW    = $clog2(TX_DEPTH);
    localparam int TX_CW    = $clog2(TX_DEPTH + 1);

    localparam logic [7:0] CH_CR = 8'h0D;
    localparam logic [7:0] CH_LF = 8'h0A;

    localparam int ERR_FRAME    = 0;
    localparam int ERR_OVERRUN  = 1;
    localparam int ERR_OVERFLOW = 2;
    localparam int ERR_NODATA   = 3;

    typedef enum logic [2:0] {
        FN_RX_BYTE  = 3'd0,
        FN_HOST_RD  = 3'd1,
        FN_HOST_WR  = 3'd2,
        FN_TX_READY = 3'd3,
        FN_CLEAR    = 3'd4
    } func_t;

    typedef enum logic {
        ST_IDLE,
        ST_READ
    } state_t;

    typedef struct packed {
        logic       tx_active;
        logic [6:0] tx_space;
        logic [5:0] rx_count;
        logic [3:0] error_status;
        logic       accepted;
        logic       data_valid;
        logic [7:0] data_out;
    } result_t;

    function automatic logic [RX_PW-1:0] rx_adv(input logic [RX_PW-1:0] p);
        return (p == RX_PW'(RX_DEPTH - 1)) ? '0 : p + 1'b1;
    endfunction

    function automatic logic [TX_PW-1:0] tx_adv(input logic [TX_PW-1:0] p);
        return (p == TX_PW'(TX_DEPTH - 1)) ? '0 : p + 1'b1;
    endfunction

    function automatic logic [RX_PW-1:0] rx_used(input logic [RX_PW-1:0] h,
                                                 input logic [RX_PW-1:0] t);
        return (h >= t) ? h - t : RX_PW'(RX_DEPTH) + h - t;
    endfunction

    function automatic logic [TX_PW-1:0] tx_used(input logic [TX_PW-1:0] h,
                                                 input logic [TX_PW-1:0] t);
        return (h >= t) ? h - t : TX_PW'(TX_DEPTH) + h - t;
    endfunction

endpackage

@@ rtl/uart_rx_tx_ring_buffers_unit.sv @@
// Top level: UART receive and transmit ring FIFOs behind one operation stream.
`timescale 1ns / 1ps

// Receive and transmit ring FIFOs of a UART, driven by one stream of operation
// beats (s_tuser selects: received byte, host read, host write, transmitter
// ready, clear both rings). Every accepted beat yields exactly one result beat
// carrying the byte taken (if any), push status, the four error flags, the
// receive fill count, the transmit space and the transmit-interrupt enable.
// Each ring lives in its own simple dual-port RAM (one write and one read
// port, registered read, 64 x 8) and keeps one slot free, so it holds at most
// 63 bytes. A received byte replaces all four flags, with frame/overrun from
// the beat and overflow set when its ring is full; a host write stores a
// newline as a carriage return and is refused when its ring is full; a host
// read from an empty ring returns zero with the no-data flag set. Rate:
// received byte, host write, clear, empty reads, empty transmit pops and
// undefined codes take one beat per cycle while the output has room; a read
// that takes a byte from a ring waits for its RAM data, registered in the
// cycle after the address. Results leave through a two-deep output stage: one
// more beat is accepted while a finished result waits on m_tready, and the input
// closes while both result registers are full and while a RAM read is in flight.
// No clearing pass after reset: RAM slots are always written before read.

module uart_rx_tx_ring_buffers_unit
    import uart_rb_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [15:0] s_tdata,   // [7:0] data_in, [8] frame_err, [9] overrun_err
    input  logic [2:0]  s_tuser,   // [2:0] func
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,   // [7:0] data_out, [8] accepted, [12:9] error_status,
                                   // [18:13] rx_count, [25:19] tx_space, [26] tx_active
    output logic        m_tuser    // [0] data_valid
);

`include "assert_macros.svh"

    // Ring storage
    logic [7:0] rx_mem [RX_DEPTH];
    logic [7:0] tx_mem [TX_DEPTH];

    // Control state
    state_t           state_reg, state_next;
    logic [RX_PW-1:0] rx_head_reg, rx_head_next, rx_tail_reg, rx_tail_next;
    logic [TX_PW-1:0] tx_head_reg, tx_head_next, tx_tail_reg, tx_tail_next;
    logic [3:0]       err_reg, err_next;
    logic             tx_irq_reg, tx_irq_next;
    logic             out_valid_reg, out_valid_next;
    logic             skid_valid_reg, skid_valid_next;

    // Payload
    result_t          out_reg;
    result_t          skid_reg;      // second result, waits behind out_reg
    result_t          pend_reg;      // status of a read waiting on RAM data
    logic             pend_tx_reg;   // waiting read comes from the transmit ring
    logic [7:0]       rx_rdata_reg, tx_rdata_reg;

    // Beat decode
    func_t            func;
    logic [7:0]       data_in;
    logic             frame_err, overrun_err;
    logic             s_accept;
    logic             out_free;
    logic             skid_free;

    // Operation results
    logic [RX_PW-1:0] rx_head_adv, rx_tail_adv;
    logic [TX_PW-1:0] tx_head_adv, tx_tail_adv;
    logic             rx_full, rx_empty, tx_full, tx_empty;
    logic             rx_we, tx_we, rx_re, tx_re;
    logic [7:0]       tx_wdata;
    logic             acc;
    result_t          res;

    // FSM outputs
    logic             load_direct, load_pend;

    // Output stage steering
    result_t          load_res;
    logic             out_take, out_from_skid, skid_take;

    assign func        = func_t'(s_tuser);
    assign data_in     = s_tdata[7:0];
    assign frame_err   = s_tdata[8];
    assign overrun_err = s_tdata[9];

    assign out_free  = !out_valid_reg || m_tready;
    assign skid_free = !skid_valid_reg;
    assign s_accept  = s_tvalid && s_tready;

    assign rx_head_adv = rx_adv(rx_head_reg);
    assign rx_tail_adv = rx_adv(rx_tail_reg);
    assign tx_head_adv = tx_adv(tx_head_reg);
    assign tx_tail_adv = tx_adv(tx_tail_reg);
    assign rx_full     = (rx_head_adv == rx_tail_reg);
    assign rx_empty    = (rx_head_reg == rx_tail_reg);
    assign tx_full     = (tx_head_adv == tx_tail_reg);
    assign tx_empty    = (tx_head_reg == tx_tail_reg);
    assign tx_wdata    = (data_in == CH_LF) ? CH_CR : data_in;

    // Operation: pointer and flag updates, RAM strobes (qualified by s_accept)
    always_comb begin
        rx_head_next = rx_head_reg;
        rx_tail_next = rx_tail_reg;
        tx_head_next = tx_head_reg;
        tx_tail_next = tx_tail_reg;
        err_next     = err_reg;
        tx_irq_next  = tx_irq_reg;
        rx_we        = 1'b0;
        tx_we        = 1'b0;
        rx_re        = 1'b0;
        tx_re        = 1'b0;
        acc          = 1'b0;
        if (s_accept) begin
            unique case (func)
                FN_RX_BYTE: begin
                    err_next = '0;
                    err_next[ERR_FRAME]   = frame_err;
                    err_next[ERR_OVERRUN] = overrun_err;
                    if (rx_full) begin
                        err_next[ERR_OVERFLOW] = 1'b1;
                    end else begin
                        rx_head_next = rx_head_adv;
                        rx_we        = 1'b1;
                        acc          = 1'b1;
                    end
                end
                FN_HOST_RD: begin
                    if (rx_empty) begin
                        err_next[ERR_NODATA] = 1'b1;
                    end else begin
                        rx_tail_next = rx_tail_adv;
                        rx_re        = 1'b1;
                    end
                end
                FN_HOST_WR: begin
                    if (!tx_full) begin
                        tx_head_next = tx_head_adv;
                        tx_we        = 1'b1;
                        tx_irq_next  = 1'b1;
                        acc          = 1'b1;
                    end
                end
                FN_TX_READY: begin
                    if (tx_empty) begin
                        tx_irq_next = 1'b0;
                    end else begin
                        tx_tail_next = tx_tail_adv;
                        tx_re        = 1'b1;
                    end
                end
                FN_CLEAR: begin
                    rx_head_next = rx_tail_reg;
                    tx_head_next = tx_tail_reg;
                end
                default: begin
                end
            endcase
        end
    end

    // Result of the beat, built from the updated state
    always_comb begin
        res              = '0;
        res.data_valid   = rx_re || tx_re;
        res.accepted     = acc;
        res.error_status = err_next;
        res.rx_count     = 6'(rx_used(rx_head_next, rx_tail_next));
        res.tx_space     = 7'(TX_CW'(TX_DEPTH) - TX_CW'(tx_used(tx_head_next, tx_tail_next)));
        res.tx_active    = tx_irq_next;
    end

    // Next state: a ring read waits in ST_READ for its RAM data and a free skid register
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: if (s_accept && (rx_re || tx_re)) state_next = ST_READ;
            ST_READ: if (skid_free)                    state_next = ST_IDLE;
            default:                                   state_next = ST_IDLE;
        endcase
    end

    // FSM outputs
    always_comb begin
        s_tready    = 1'b0;
        load_direct = 1'b0;
        load_pend   = 1'b0;
        unique case (state_reg)
            ST_IDLE: begin
                s_tready    = skid_free;
                load_direct = s_accept && !(rx_re || tx_re);
            end
            ST_READ: begin
                load_pend = skid_free;
            end
            default: begin
            end
        endcase
    end

    // Finished result: direct status, or waiting read status plus RAM data
    always_comb begin
        if (load_pend) begin
            load_res          = pend_reg;
            load_res.data_out = pend_tx_reg ? tx_rdata_reg : rx_rdata_reg;
        end else begin
            load_res = res;
        end
    end

    // Two-deep output stage; the skid register only fills behind a stalled out_reg
    always_comb begin
        out_valid_next  = out_valid_reg;
        skid_valid_next = skid_valid_reg;
        out_take        = 1'b0;
        out_from_skid   = 1'b0;
        skid_take       = 1'b0;
        if (skid_valid_reg) begin
            if (m_tready) begin
                out_from_skid   = 1'b1;
                skid_valid_next = 1'b0;
            end
        end else if (load_direct || load_pend) begin
            if (out_free) begin
                out_take       = 1'b1;
                out_valid_next = 1'b1;
            end else begin
                skid_take       = 1'b1;
                skid_valid_next = 1'b1;
            end
        end else if (m_tready) begin
            out_valid_next = 1'b0;
        end
    end

    // RAMs: write and registered read. A read never shares an edge with a
    // write to the same ring, so no forwarding is needed.
    always_ff @(posedge aclk) begin
        if (rx_we) rx_mem[rx_head_adv] <= data_in;
        if (rx_re) rx_rdata_reg <= rx_mem[rx_tail_adv];
    end

    always_ff @(posedge aclk) begin
        if (tx_we) tx_mem[tx_head_adv] <= tx_wdata;
        if (tx_re) tx_rdata_reg <= tx_mem[tx_tail_adv];
    end

    // Control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_IDLE;
            rx_head_reg    <= '0;
            rx_tail_reg    <= '0;
            tx_head_reg    <= '0;
            tx_tail_reg    <= '0;
            err_reg        <= '0;
            tx_irq_reg     <= 1'b0;
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else begin
            state_reg      <= state_next;
            rx_head_reg    <= rx_head_next;
            rx_tail_reg    <= rx_tail_next;
            tx_head_reg    <= tx_head_next;
            tx_tail_reg    <= tx_tail_next;
            err_reg        <= err_next;
            tx_irq_reg     <= tx_irq_next;
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    // Payload registers
    always_ff @(posedge aclk) begin
        if (s_accept) begin
            pend_reg    <= res;
            pend_tx_reg <= tx_re;
        end
        if (out_take) begin
            out_reg <= load_res;
        end else if (out_from_skid) begin
            out_reg <= skid_reg;
        end
        if (skid_take) begin
            skid_reg <= load_res;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tuser  = out_reg.data_valid;
    assign m_tdata  = {5'b0, out_reg.tx_active, out_reg.tx_space, out_reg.rx_count,
                       out_reg.error_status, out_reg.accepted, out_reg.data_out};

    // Checks
    `ASSERT_PROP(a_read_blocks_input, aclk, aresetn,
                 (state_reg == ST_READ) |-> !s_tready)
    `ASSERT_PROP(a_ring_read_waits, aclk, aresetn,
                 (s_accept && (rx_re || tx_re)) |=> (state_reg == ST_READ))
    `ASSERT_NEVER(a_valid_and_accepted, aclk, aresetn,
                  out_valid_reg && out_reg.data_valid && out_reg.accepted)
    `ASSERT_PROP(a_write_arms_irq, aclk, aresetn,
                 (s_accept && (func == FN_HOST_WR) && !tx_full) |=> tx_irq_reg)
    `ASSERT_NEVER(a_skid_behind_out, aclk, aresetn,
                  skid_valid_reg && !out_valid_reg)

endmodule

@@ bench/uart_rx_tx_ring_buffers_unit_tb.sv @@
// Testbench for the UART receive/transmit ring FIFO unit: random op stream, in-order result check.
`timescale 1ns / 1ps

module uart_rx_tx_ring_buffers_unit_tb
    import uart_rb_pkg::*;
();

    // Operation codes past FN_CLEAR are undefined; the unit reports status only.
    localparam logic [2:0] FN_UNUSED_LO  = 3'd5;
    localparam logic [2:0] FN_UNUSED_MID = 3'd6;
    localparam logic [2:0] FN_UNUSED_HI  = 3'd7;

    localparam int OP_TARGET   = 1100;    // defined ops to send in the random part
    localparam int MAX_WAIT    = 17;      // longest per-beat gap / stall
    localparam int LONG_HOLD   = 300;     // receiver hold-off used to back up the unit
    localparam int TAIL_CYCLES = 10;      // settle time after the last result
    localparam int CYCLE_LIMIT = 500000;  // watchdog

    typedef enum {
        PH_RX_FILL,
        PH_RX_DRAIN,
        PH_TX_FILL,
        PH_TX_DRAIN,
        PH_MIXED
    } phase_t;

    // One expected result beat, unpacked from m_tdata / m_tuser.
    typedef struct {
        logic [7:0] data_out;
        logic       data_valid;
        logic       accepted;
        logic [3:0] error_status;
        logic [5:0] rx_count;
        logic [6:0] tx_space;
        logic       tx_active;
    } ring_reply_t;

    // Mirrors both rings and the status flags; queues the reply owed for each op beat
    // and checks result beats against them in order.
    class uart_ring_tracker;
        logic [7:0]  rx_mem [RX_DEPTH];
        logic [7:0]  tx_mem [TX_DEPTH];
        int          rx_wr, rx_rd, tx_wr, tx_rd;   // head = last written, tail = last read
        logic [3:0]  err;
        logic        tx_irq;
        ring_reply_t replies_due[$];
        int          errors, n_overflow, n_refused, n_empty_rd, n_empty_tx;

        function new();
            rx_wr = 0; rx_rd = 0; tx_wr = 0; tx_rd = 0;
            err = '0;
            tx_irq = 1'b0;
            errors = 0; n_overflow = 0; n_refused = 0; n_empty_rd = 0; n_empty_tx = 0;
        endfunction

        function int step_ptr(int p, int depth);
            return (p + 1 >= depth) ? 0 : p + 1;
        endfunction

        function int ring_used(int h, int t, int depth);
            return (depth + h - t) % depth;
        endfunction

        function int pending();
            return replies_due.size();
        endfunction

        function void note_op(logic [2:0] code, logic [7:0] value, logic fe, logic ov);
            ring_reply_t r;
            int          nx;
            r = '{default: '0};
            case (code)
                FN_RX_BYTE: begin
                    // flags are replaced, not accumulated
                    err = '0;
                    err[ERR_FRAME]   = fe;
                    err[ERR_OVERRUN] = ov;
                    nx = step_ptr(rx_wr, RX_DEPTH);
                    if (nx == rx_rd) begin
                        err[ERR_OVERFLOW] = 1'b1;
                        n_overflow++;
                    end else begin
                        rx_mem[nx] = value;
                        rx_wr = nx;
                        r.accepted = 1'b1;
                    end
                end
                FN_HOST_RD: begin
                    if (rx_wr == rx_rd) begin
                        err[ERR_NODATA] = 1'b1;
                        n_empty_rd++;
                    end else begin
                        rx_rd = step_ptr(rx_rd, RX_DEPTH);
                        r.data_out = rx_mem[rx_rd];
                        r.data_valid = 1'b1;
                    end
                end
                FN_HOST_WR: begin
                    nx = step_ptr(tx_wr, TX_DEPTH);
                    if (nx == tx_rd) begin
                        n_refused++;
                    end else begin
                        tx_mem[nx] = (value == CH_LF) ? CH_CR : value;
                        tx_wr = nx;
                        tx_irq = 1'b1;
                        r.accepted = 1'b1;
                    end
                end
                FN_TX_READY: begin
                    if (tx_wr == tx_rd) begin
                        tx_irq = 1'b0;
                        n_empty_tx++;
                    end else begin
                        tx_rd = step_ptr(tx_rd, TX_DEPTH);
                        r.data_out = tx_mem[tx_rd];
                        r.data_valid = 1'b1;
                    end
                end
                FN_CLEAR: begin
                    tx_wr = tx_rd;
                    rx_wr = rx_rd;
                end
                default: ;
            endcase
            r.error_status = err;
            r.rx_count     = 6'(ring_used(rx_wr, rx_rd, RX_DEPTH));
            r.tx_space     = 7'(TX_DEPTH - ring_used(tx_wr, tx_rd, TX_DEPTH));
            r.tx_active    = tx_irq;
            replies_due.push_back(r);
        endfunction

        function void compare_field(string field, logic [7:0] want, logic [7:0] got);
            if (got !== want) begin
                $error("%s: expected 0x%0h, actual 0x%0h", field, want, got);
                errors++;
            end
        endfunction

        function void check_reply(ring_reply_t got);
            ring_reply_t want;
            if (replies_due.size() == 0) begin
                $error("result beat with no op outstanding");
                errors++;
                return;
            end
            want = replies_due.pop_front();
            compare_field("data_out",     want.data_out,     got.data_out);
            compare_field("data_valid",   want.data_valid,   got.data_valid);
            compare_field("accepted",     want.accepted,     got.accepted);
            compare_field("error_status", want.error_status, got.error_status);
            compare_field("rx_count",     want.rx_count,     got.rx_count);
            compare_field("tx_space",     want.tx_space,     got.tx_space);
            compare_field("tx_active",    want.tx_active,    got.tx_active);
        endfunction
    endclass

    logic        aclk;
    logic        aresetn;
    logic        s_tvalid;
    logic        s_tready;
    logic [15:0] s_tdata;    // [7:0] data_in, [8] frame_err, [9] overrun_err
    logic [2:0]  s_tuser;    // [2:0] func
    logic        m_tvalid;
    logic        m_tready;
    logic [31:0] m_tdata;    // [7:0] data_out, [8] accepted, [12:9] error_status,
                             // [18:13] rx_count, [25:19] tx_space, [26] tx_active
    logic        m_tuser;    // [0] data_valid

    uart_ring_tracker tracker;

    bit src_busy;            // sender inserts random gaps
    bit snk_busy;            // receiver inserts random stalls
    int hold_cycles;         // one-shot long receiver hold-off, picked up by the receiver
    int defined_ops;         // ops with a defined func accepted so far
    int op_tally [8];
    int results_seen;
    int cycle_count;

    uart_rx_tx_ring_buffers_unit DUT (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    // 8 ns clock
    initial aclk = 1'b0;
    always begin
        #4 aclk = 1'b1;
        #4 aclk = 1'b0;
    end

    // Watchdog: a hung handshake ends the run as a failure.
    initial begin
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge aclk);
            cycle_count++;
        end
        $display("TB_ERROR");
        $finish;
    end

    // Mostly random bytes, with newlines common enough to hit the CR substitution.
    function automatic logic [7:0] pick_byte();
        return ($urandom_range(0, 5) == 0) ? CH_LF : 8'($urandom);
    endfunction

    // Offer one op beat; valid stays up across back-to-back beats.
    task automatic send_op(input logic [2:0] code, input logic [7:0] value,
                           input logic fe, input logic ov);
        int gap;
        gap = src_busy ? $urandom_range(0, MAX_WAIT) : 0;
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= code;
        s_tdata  <= {6'b0, ov, fe, value};
        do @(posedge aclk); while (!s_tready);
        tracker.note_op(code, value, fe, ov);
        op_tally[code]++;
        if (code <= FN_CLEAR)
            defined_ops++;
    endtask

    task automatic send_random_op(input logic [2:0] code);
        send_op(code, pick_byte(), ($urandom_range(0, 3) == 0), ($urandom_range(0, 3) == 0));
    endtask

    // Sender stops until every result owed has come back.
    task automatic wait_drained();
        s_tvalid <= 1'b0;
        while (tracker.pending() != 0)
            @(posedge aclk);
    endtask

    // Each phase but PH_MIXED leans on one op so the rings reach full and empty; the rest is noise.
    task automatic run_phase(input phase_t kind, input int len);
        int         r;
        logic [2:0] code;
        for (int i = 0; i < len; i++) begin
            r = $urandom_range(0, 99);
            if (r < 2) begin
                code = 3'($urandom_range(FN_UNUSED_LO, FN_UNUSED_HI));
            end else if (r < ((kind == PH_MIXED) ? 5 : 3)) begin
                code = FN_CLEAR;
            end else if (r < 90 && kind != PH_MIXED) begin
                case (kind)
                    PH_RX_FILL:  code = FN_RX_BYTE;
                    PH_RX_DRAIN: code = FN_HOST_RD;
                    PH_TX_FILL:  code = FN_HOST_WR;
                    default:     code = FN_TX_READY;
                endcase
            end else begin
                code = 3'($urandom_range(FN_RX_BYTE, FN_TX_READY));
            end
            send_random_op(code);
        end
    endtask

    // Result side: random stalls per beat, plus the one-shot long hold-off.
    initial begin
        ring_reply_t got;
        int          w;
        m_tready <= 1'b0;
        wait (aresetn === 1'b1);
        forever begin
            if (hold_cycles > 0) begin
                w = hold_cycles;
                hold_cycles = 0;
            end else begin
                w = snk_busy ? $urandom_range(0, MAX_WAIT) : 0;
            end
            if (w > 0) begin
                m_tready <= 1'b0;
                repeat (w) @(posedge aclk);
            end
            m_tready <= 1'b1;
            do @(posedge aclk); while (!m_tvalid);
            got.data_out     = m_tdata[7:0];
            got.accepted     = m_tdata[8];
            got.error_status = m_tdata[12:9];
            got.rx_count     = m_tdata[18:13];
            got.tx_space     = m_tdata[25:19];
            got.tx_active    = m_tdata[26];
            got.data_valid   = m_tuser;
            tracker.check_reply(got);
            results_seen++;
        end
    end

    initial begin
        phase_t kind;
        int     phase_no;
        tracker      = new();
        src_busy     = 1'b1;
        snk_busy     = 1'b1;
        hold_cycles  = 0;
        defined_ops  = 0;
        results_seen = 0;
        phase_no     = 0;
        foreach (op_tally[k]) op_tally[k] = 0;

        aresetn  <= 1'b0;
        s_tvalid <= 1'b0;
        s_tdata  <= '0;
        s_tuser  <= FN_RX_BYTE;
        repeat (3) @(posedge aclk);
        aresetn  <= 1'b1;

        // --- directed: empty rings, flag combos, byte extremes, newline, clear, unused codes
        send_op(FN_HOST_RD,  8'h00, 1'b0, 1'b0);   // empty read -> no-data flag
        send_op(FN_TX_READY, 8'h00, 1'b0, 1'b0);   // empty transmit pop
        send_op(FN_RX_BYTE,  8'h00, 1'b0, 1'b0);
        send_op(FN_RX_BYTE,  8'hFF, 1'b1, 1'b1);
        send_op(FN_RX_BYTE,  8'h55, 1'b1, 1'b0);
        send_op(FN_RX_BYTE,  8'hAA, 1'b0, 1'b1);
        send_op(FN_HOST_RD,  8'hFF, 1'b1, 1'b1);
        send_op(FN_HOST_RD,  8'h00, 1'b0, 1'b0);
        send_op(FN_HOST_RD,  8'h00, 1'b0, 1'b0);
        send_op(FN_HOST_WR,  CH_LF, 1'b0, 1'b0);   // newline stored as carriage return
        send_op(FN_HOST_WR,  CH_CR, 1'b0, 1'b0);
        send_op(FN_HOST_WR,  8'hFF, 1'b1, 1'b1);
        send_op(FN_HOST_WR,  8'h00, 1'b0, 1'b0);
        send_op(FN_TX_READY, 8'h00, 1'b0, 1'b0);
        send_op(FN_TX_READY, 8'h00, 1'b0, 1'b0);
        send_op(FN_CLEAR,    8'h00, 1'b0, 1'b0);   // rx holds one byte, tx two
        send_op(FN_HOST_RD,  8'h00, 1'b0, 1'b0);
        send_op(FN_TX_READY, 8'h00, 1'b0, 1'b0);
        send_op(FN_UNUSED_LO,  8'hFF, 1'b1, 1'b1);
        send_op(FN_UNUSED_MID, 8'h00, 1'b0, 1'b0);
        send_op(FN_UNUSED_HI,  8'h5A, 1'b1, 1'b0);
        wait_drained();

        // --- random phases
        defined_ops = 0;
        while (defined_ops < OP_TARGET) begin
            if (phase_no == 2) begin
                // receiver holds off while the sender streams: unit must stall its input
                src_busy    = 1'b0;
                snk_busy    = 1'b0;
                hold_cycles = LONG_HOLD;
                run_phase(PH_RX_FILL, 100);
            end else begin
                src_busy = ($urandom_range(0, 2) != 0);
                snk_busy = ($urandom_range(0, 2) != 0);
                kind     = phase_t'($urandom_range(PH_RX_FILL, PH_MIXED));
                run_phase(kind, $urandom_range(40, 110));
            end
            if (phase_no % 4 == 3)
                wait_drained();
            phase_no++;
        end

        wait_drained();
        repeat (TAIL_CYCLES) @(posedge aclk);

        $display("ran %0d results/%0d phases: rx %0d rd %0d wr %0d txrdy %0d clr %0d undef %0d",
                 results_seen, phase_no, op_tally[FN_RX_BYTE], op_tally[FN_HOST_RD],
                 op_tally[FN_HOST_WR], op_tally[FN_TX_READY], op_tally[FN_CLEAR],
                 op_tally[FN_UNUSED_LO] + op_tally[FN_UNUSED_MID] + op_tally[FN_UNUSED_HI]);
        $display("rx overflows %0d, refused writes %0d, empty reads %0d, empty tx pops %0d",
                 tracker.n_overflow, tracker.n_refused, tracker.n_empty_rd, tracker.n_empty_tx);
        if (tracker.errors == 0 && tracker.pending() == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule
